[rtl/core/srec_pkg.sv]
package srec_pkg;

  // Data bytes per S1 record
  localparam int REC_BYTES = 16;
  localparam int IDX_W     = (REC_BYTES > 1) ? $clog2(REC_BYTES) : 1;
  localparam int CNT_W     = $clog2(REC_BYTES + 1);
  // byte position inside a record: count, two address bytes, data, checksum
  localparam int BIDX_W    = $clog2(REC_BYTES + 5);
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  // input function codes
  localparam logic [1:0] FUNC_DATA   = 2'd0;
  localparam logic [1:0] FUNC_ORIGIN = 2'd1;
  localparam logic [1:0] FUNC_END    = 2'd2;

  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_NL   = 8'h0a;
  localparam logic [7:0] S9_CNT  = 8'h03;
  localparam logic [7:0] ADDR_BYTES_PLUS_SUM = 8'd3;

  // command handed from front to back
  typedef struct packed {
    logic              flush;
    logic              fin;
    logic              append;
    logic [CNT_W-1:0]  flush_n;
    logic [15:0]       rec_addr;
    logic [15:0]       start_addr;
    logic [7:0]        data;
    logic [IDX_W-1:0]  idx;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_S,
    ST_TYPE,
    ST_HI,
    ST_LO,
    ST_NL
  } back_state_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] n8;
    n8 = {4'd0, nib};
    if (nib < 4'd10) begin
      hex_char = n8 + 8'h30;
    end else begin
      hex_char = n8 + 8'h37;
    end
  endfunction

endpackage

[rtl/core/srec_front.sv]
module srec_front
  import srec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_address,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [15:0]      rec_addr_r, rec_addr_nxt;
  logic [15:0]      next_addr_r, next_addr_nxt;
  logic             accept;
  logic             full;
  logic [CNT_W-1:0] base_fill;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign full     = (fill_r == CNT_W'(REC_BYTES));
  assign base_fill = full ? '0 : fill_r;

  // classify the word and update buffer bookkeeping
  always_comb begin
    fill_nxt      = fill_r;
    rec_addr_nxt  = rec_addr_r;
    next_addr_nxt = next_addr_r;
    q_push        = 1'b0;
    q_cmd.flush      = 1'b0;
    q_cmd.fin        = 1'b0;
    q_cmd.append     = 1'b0;
    q_cmd.flush_n    = fill_r;
    q_cmd.rec_addr   = rec_addr_r;
    q_cmd.start_addr = in_address;
    q_cmd.data       = in_data_byte;
    q_cmd.idx        = base_fill[IDX_W-1:0];
    if (accept) begin
      case (in_func)
        FUNC_DATA: begin
          q_push        = 1'b1;
          q_cmd.flush   = full;
          q_cmd.append  = 1'b1;
          fill_nxt      = base_fill + CNT_W'(1);
          if (base_fill == '0) rec_addr_nxt = next_addr_r;
          next_addr_nxt = next_addr_r + 16'd1;
        end
        FUNC_ORIGIN: begin
          q_push        = (fill_r != '0);
          q_cmd.flush   = 1'b1;
          fill_nxt      = '0;
          next_addr_nxt = in_address;
        end
        FUNC_END: begin
          q_push      = 1'b1;
          q_cmd.flush = (fill_r != '0);
          q_cmd.fin   = 1'b1;
          fill_nxt    = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      rec_addr_r  <= '0;
      next_addr_r <= '0;
    end else begin
      fill_r      <= fill_nxt;
      rec_addr_r  <= rec_addr_nxt;
      next_addr_r <= next_addr_nxt;
    end
  end

endmodule

[rtl/core/srec_cmdq.sv]
module srec_cmdq
  import srec_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  // pointer and count update
  always_comb begin
    wr_nxt  = do_push ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    if (!do_push && do_pop) cnt_nxt = cnt_r - (QPTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_cmd;
  end

endmodule

[rtl/core/srec_back.sv]
module srec_back
  import srec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_record_end,
  output logic        out_last
);

  back_state_t state_r, state_nxt;

  logic [7:0]        buf_r [REC_BYTES];
  logic              kind9_r, kind9_nxt;
  logic              fin_r, fin_nxt;
  logic              app_r, app_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [15:0]       addr_r, addr_nxt;
  logic [15:0]       start_r, start_nxt;
  logic [7:0]        dat_r, dat_nxt;
  logic [IDX_W-1:0]  widx_r, widx_nxt;
  logic [BIDX_W-1:0] bidx_r, bidx_nxt;
  logic [7:0]        sum_r, sum_nxt;

  logic              ov_r, ov_nxt;
  logic [7:0]        och_r, och_nxt;
  logic              orec_r, orec_nxt;
  logic              olast_r, olast_nxt;

  logic              can_load;
  logic              is_sum;
  logic [BIDX_W-1:0] didx;
  logic [7:0]        cur_byte;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [7:0]        wr_data;
  logic              chain9;

  assign can_load = !ov_r || !out_stall;
  assign chain9   = !kind9_r && fin_r;

  // byte currently being printed as two hex digits
  assign is_sum = (bidx_r == BIDX_W'(n_r) + BIDX_W'(3));
  assign didx   = bidx_r - BIDX_W'(3);
  always_comb begin
    if (bidx_r == BIDX_W'(0)) begin
      cur_byte = 8'(n_r) + ADDR_BYTES_PLUS_SUM;
    end else if (bidx_r == BIDX_W'(1)) begin
      cur_byte = addr_r[15:8];
    end else if (bidx_r == BIDX_W'(2)) begin
      cur_byte = addr_r[7:0];
    end else if (is_sum) begin
      cur_byte = ~sum_r;
    end else begin
      cur_byte = buf_r[didx[IDX_W-1:0]];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (!q_empty && (q_head.flush || q_head.fin)) state_nxt = ST_S;
      ST_S:    if (can_load) state_nxt = ST_TYPE;
      ST_TYPE: if (can_load) state_nxt = ST_HI;
      ST_HI:   if (can_load) state_nxt = ST_LO;
      ST_LO:   if (can_load) state_nxt = is_sum ? ST_NL : ST_HI;
      ST_NL:   if (can_load) state_nxt = chain9 ? ST_S : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs, record registers and buffer writes
  always_comb begin
    q_pop     = 1'b0;
    kind9_nxt = kind9_r;
    fin_nxt   = fin_r;
    app_nxt   = app_r;
    n_nxt     = n_r;
    addr_nxt  = addr_r;
    start_nxt = start_r;
    dat_nxt   = dat_r;
    widx_nxt  = widx_r;
    bidx_nxt  = bidx_r;
    sum_nxt   = sum_r;
    ov_nxt    = ov_r && out_stall;
    och_nxt   = och_r;
    orec_nxt  = orec_r;
    olast_nxt = olast_r;
    wr_en     = 1'b0;
    wr_idx    = widx_r;
    wr_data   = dat_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          fin_nxt   = q_head.fin;
          app_nxt   = q_head.append;
          start_nxt = q_head.start_addr;
          dat_nxt   = q_head.data;
          widx_nxt  = q_head.idx;
          if (q_head.flush) begin
            kind9_nxt = 1'b0;
            n_nxt     = q_head.flush_n;
            addr_nxt  = q_head.rec_addr;
          end else begin
            kind9_nxt = 1'b1;
            n_nxt     = '0;
            addr_nxt  = q_head.start_addr;
          end
          // plain append: nothing to print
          if (!q_head.flush && !q_head.fin) begin
            wr_en   = q_head.append;
            wr_idx  = q_head.idx;
            wr_data = q_head.data;
          end
        end
      end
      ST_S: begin
        if (can_load) begin
          ov_nxt = 1'b1; och_nxt = CH_S; orec_nxt = 1'b0; olast_nxt = 1'b0;
        end
      end
      ST_TYPE: begin
        if (can_load) begin
          ov_nxt = 1'b1; och_nxt = kind9_r ? CH_9 : CH_1;
          orec_nxt = 1'b0; olast_nxt = 1'b0;
          bidx_nxt = '0;
          sum_nxt  = '0;
        end
      end
      ST_HI: begin
        if (can_load) begin
          ov_nxt = 1'b1; och_nxt = hex_char(cur_byte[7:4]);
          orec_nxt = 1'b0; olast_nxt = 1'b0;
        end
      end
      ST_LO: begin
        if (can_load) begin
          ov_nxt = 1'b1; och_nxt = hex_char(cur_byte[3:0]);
          orec_nxt = 1'b0; olast_nxt = 1'b0;
          sum_nxt  = sum_r + cur_byte;
          bidx_nxt = bidx_r + BIDX_W'(1);
        end
      end
      ST_NL: begin
        if (can_load) begin
          ov_nxt = 1'b1; och_nxt = CH_NL;
          orec_nxt = 1'b1; olast_nxt = !chain9;
          if (chain9) begin
            // end marker after a flush: S9 with the start address
            kind9_nxt = 1'b1;
            n_nxt     = '0;
            addr_nxt  = start_r;
          end else begin
            wr_en = app_r;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = ov_r;
  assign out_char       = och_r;
  assign out_record_end = orec_r;
  assign out_last       = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind9_r <= kind9_nxt;
    fin_r   <= fin_nxt;
    app_r   <= app_nxt;
    n_r     <= n_nxt;
    addr_r  <= addr_nxt;
    start_r <= start_nxt;
    dat_r   <= dat_nxt;
    widx_r  <= widx_nxt;
    bidx_r  <= bidx_nxt;
    sum_r   <= sum_nxt;
    och_r   <= och_nxt;
    orec_r  <= orec_nxt;
    olast_r <= olast_nxt;
  end

  // byte buffer
  always_ff @(posedge clk) begin
    if (wr_en) buf_r[wr_idx] <= wr_data;
  end

endmodule

[rtl/core/srecord_encoder_unit.sv]
// S1/S9 record encoder.
// Input channel (in_valid / in_stall): one word per item, in_func selects a
// data byte, an origin change (in_address) or the end marker (in_address
// holds the start address). Output channel (out_valid / out_stall): one
// ASCII character per word, out_record_end on each closing newline, out_last
// on the final character caused by one input word.
// A front stage keeps the fill count and addresses and posts commands into
// a four-entry queue; a back sequencer prints records from the byte buffer.
// Throughput is set by the back sequencer: one character per cycle while
// out_stall does not hold it; a data byte that only fills the buffer costs
// the sequencer a single queue pop. The command queue lets the front accept
// further words while the sequencer prints a record.
// in_stall rises only while the command queue is full.
// When out_stall is high a pending output word holds and the sequencer waits.
// Reset (rst_n low, synchronous) empties the buffer and queue and sets both
// addresses to zero.
module srecord_encoder_unit
  import srec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_record_end,
  output logic        out_last
);

  cmd_t push_cmd, head_cmd;
  logic push, q_full, q_pop, q_empty;

  srec_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_data_byte (in_data_byte),
    .in_address   (in_address),
    .q_full       (q_full),
    .q_push       (push),
    .q_cmd        (push_cmd)
  );

  srec_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_cmd)
  );

  srec_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (head_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_record_end (out_record_end),
    .out_last       (out_last)
  );

endmodule
